### rtl/aat_pkg.sv
// Shared constants and types for the AABB affine transform block.
package aat_pkg;

    // Default coordinate width (signed Q16.16)
    localparam int COORD_WIDTH_DEF = 32;

    // Matrix entry format: signed Q8.24
    localparam int MAT_W    = 32;
    localparam int MAT_FRAC = 24;

    // Configuration register file
    localparam int CFG_NUM    = 6;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_ROW0_COLS01 = 3'd0;
    localparam t_cfg_idx CFG_ROW0_COLS23 = 3'd1;
    localparam t_cfg_idx CFG_ROW1_COLS01 = 3'd2;
    localparam t_cfg_idx CFG_ROW1_COLS23 = 3'd3;
    localparam t_cfg_idx CFG_ROW2_COLS01 = 3'd4;
    localparam t_cfg_idx CFG_ROW2_COLS23 = 3'd5;

    // Reset values: identity matrix, zero translation
    localparam t_cfg_data RST_ROW0_COLS01 = 64'h0000_0000_0100_0000;
    localparam t_cfg_data RST_ROW0_COLS23 = 64'h0000_0000_0000_0000;
    localparam t_cfg_data RST_ROW1_COLS01 = 64'h0100_0000_0000_0000;
    localparam t_cfg_data RST_ROW1_COLS23 = 64'h0000_0000_0000_0000;
    localparam t_cfg_data RST_ROW2_COLS01 = 64'h0000_0000_0000_0000;
    localparam t_cfg_data RST_ROW2_COLS23 = 64'h0000_0000_0100_0000;

    // Per-stage load enables of the datapath
    typedef struct packed {
        logic s1;   // partial products
        logic s2;   // rounded products
        logic s3;   // per-term min and max
        logic s4;   // row sums, saturated output
    } t_stage_ld;

endpackage

### rtl/aat_box_in_if.sv
// Input item channel: one axis-aligned box per item.
interface aat_box_in_if #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] box_min_x;
    logic signed [COORD_WIDTH-1:0] box_min_y;
    logic signed [COORD_WIDTH-1:0] box_min_z;
    logic signed [COORD_WIDTH-1:0] box_max_x;
    logic signed [COORD_WIDTH-1:0] box_max_y;
    logic signed [COORD_WIDTH-1:0] box_max_z;

    modport source (
        output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  ready
    );
    modport sink (
        input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output ready
    );
endinterface

### rtl/aat_box_out_if.sv
// Result item channel: the transformed axis-aligned box.
interface aat_box_out_if #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_min_x;
    logic signed [COORD_WIDTH-1:0] out_min_y;
    logic signed [COORD_WIDTH-1:0] out_min_z;
    logic signed [COORD_WIDTH-1:0] out_max_x;
    logic signed [COORD_WIDTH-1:0] out_max_y;
    logic signed [COORD_WIDTH-1:0] out_max_z;

    modport source (
        output valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
        input  ready
    );
    modport sink (
        input  valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
        output ready
    );
endinterface

### rtl/aat_cfg_regs.sv
// Matrix and translation register file with its write port.
module aat_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  aat_pkg::t_cfg_idx              i_idx,
    input  aat_pkg::t_cfg_data             i_data,
    output logic signed [aat_pkg::MAT_W-1:0] o_mat   [3][3],
    output logic signed [aat_pkg::MAT_W-1:0] o_trans [3]
);

    aat_pkg::t_cfg_data r_regs [aat_pkg::CFG_NUM];

    // Load reset values, then take writes; drop indexes past the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs[0] <= aat_pkg::RST_ROW0_COLS01;
            r_regs[1] <= aat_pkg::RST_ROW0_COLS23;
            r_regs[2] <= aat_pkg::RST_ROW1_COLS01;
            r_regs[3] <= aat_pkg::RST_ROW1_COLS23;
            r_regs[4] <= aat_pkg::RST_ROW2_COLS01;
            r_regs[5] <= aat_pkg::RST_ROW2_COLS23;
        end else if (i_we) begin
            unique case (i_idx)
                aat_pkg::CFG_ROW0_COLS01: r_regs[0] <= i_data;
                aat_pkg::CFG_ROW0_COLS23: r_regs[1] <= i_data;
                aat_pkg::CFG_ROW1_COLS01: r_regs[2] <= i_data;
                aat_pkg::CFG_ROW1_COLS23: r_regs[3] <= i_data;
                aat_pkg::CFG_ROW2_COLS01: r_regs[4] <= i_data;
                aat_pkg::CFG_ROW2_COLS23: r_regs[5] <= i_data;
                default: ;
            endcase
        end
    end

    // Split each register pair into coefficients and translation
    for (genvar r = 0; r < 3; r++) begin : g_row
        assign o_mat[r][0] = $signed(r_regs[2*r][31:0]);
        assign o_mat[r][1] = $signed(r_regs[2*r][63:32]);
        assign o_mat[r][2] = $signed(r_regs[2*r+1][31:0]);
        assign o_trans[r]  = $signed(r_regs[2*r+1][63:32]);
    end

endmodule

### rtl/aat_term.sv
// One matrix term: rounded products of the low and high coordinate, and their min and max.
module aat_term #(
    parameter  int COORD_WIDTH = aat_pkg::COORD_WIDTH_DEF,
    localparam int PROD_W      = COORD_WIDTH + aat_pkg::MAT_W - aat_pkg::MAT_FRAC
) (
    input  logic                             i_clk,
    input  aat_pkg::t_stage_ld               i_ld,
    input  logic signed [COORD_WIDTH-1:0]    i_lo,
    input  logic signed [COORD_WIDTH-1:0]    i_hi,
    input  logic signed [aat_pkg::MAT_W-1:0] i_coef,
    output logic signed [PROD_W-1:0]         o_min,
    output logic signed [PROD_W-1:0]         o_max
);

    localparam int LO_W   = COORD_WIDTH / 2;
    localparam int HI_W   = COORD_WIDTH - LO_W;
    localparam int A_W    = HI_W + aat_pkg::MAT_W;
    localparam int B_W    = LO_W + aat_pkg::MAT_W;
    localparam int FULL_W = COORD_WIDTH + aat_pkg::MAT_W;
    localparam logic signed [FULL_W-1:0] ROUND_BIAS = FULL_W'(1) << (aat_pkg::MAT_FRAC - 1);

    logic signed [A_W-1:0]    n_a_lo, n_a_hi, r_a_lo, r_a_hi;
    logic signed [B_W-1:0]    n_b_lo, n_b_hi;
    logic signed [B_W-1:0]    r_b_lo, r_b_hi;
    logic signed [FULL_W-1:0] n_full_lo, n_full_hi;
    logic signed [PROD_W-1:0] r_p_lo, r_p_hi, r_min, r_max;

    // Stage 1: split each coordinate into a signed high part and an unsigned low part
    assign n_a_lo = $signed(i_lo[COORD_WIDTH-1:LO_W]) * i_coef;
    assign n_a_hi = $signed(i_hi[COORD_WIDTH-1:LO_W]) * i_coef;
    assign n_b_lo = $signed({1'b0, i_lo[LO_W-1:0]}) * i_coef;
    assign n_b_hi = $signed({1'b0, i_hi[LO_W-1:0]}) * i_coef;

    always_ff @(posedge i_clk) begin
        if (i_ld.s1) begin
            r_a_lo <= n_a_lo;
            r_a_hi <= n_a_hi;
            r_b_lo <= n_b_lo;
            r_b_hi <= n_b_hi;
        end
    end

    // Stage 2: recombine, add half an LSB and drop the extra fraction bits
    assign n_full_lo = (FULL_W'(r_a_lo) <<< LO_W) + FULL_W'(r_b_lo) + ROUND_BIAS;
    assign n_full_hi = (FULL_W'(r_a_hi) <<< LO_W) + FULL_W'(r_b_hi) + ROUND_BIAS;

    always_ff @(posedge i_clk) begin
        if (i_ld.s2) begin
            r_p_lo <= n_full_lo[FULL_W-1:aat_pkg::MAT_FRAC];
            r_p_hi <= n_full_hi[FULL_W-1:aat_pkg::MAT_FRAC];
        end
    end

    // Stage 3: the rounded product is monotone in the coordinate, so order the two ends
    always_ff @(posedge i_clk) begin
        if (i_ld.s3) begin
            r_min <= (r_p_hi < r_p_lo) ? r_p_hi : r_p_lo;
            r_max <= (r_p_hi < r_p_lo) ? r_p_lo : r_p_hi;
        end
    end

    assign o_min = r_min;
    assign o_max = r_max;

endmodule

### rtl/aat_row_sum.sv
// One output axis: sum of term extremes plus translation, saturated into the output register.
module aat_row_sum #(
    parameter  int COORD_WIDTH = aat_pkg::COORD_WIDTH_DEF,
    localparam int PROD_W      = COORD_WIDTH + aat_pkg::MAT_W - aat_pkg::MAT_FRAC
) (
    input  logic                             i_clk,
    input  aat_pkg::t_stage_ld               i_ld,
    input  logic signed [PROD_W-1:0]         i_min [3],
    input  logic signed [PROD_W-1:0]         i_max [3],
    input  logic signed [aat_pkg::MAT_W-1:0] i_trans,
    output logic signed [COORD_WIDTH-1:0]    o_min,
    output logic signed [COORD_WIDTH-1:0]    o_max
);

    localparam int SUM_W = ((PROD_W > aat_pkg::MAT_W) ? PROD_W : aat_pkg::MAT_W) + 2;

    logic signed [SUM_W-1:0]       n_sum_min, n_sum_max;
    logic signed [COORD_WIDTH-1:0] r_min, r_max;

    // Clamp to the signed coordinate range
    function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic pos_ovf;
        logic neg_ovf;
        pos_ovf = !v[SUM_W-1] && (|v[SUM_W-2:COORD_WIDTH-1]);
        neg_ovf =  v[SUM_W-1] && !(&v[SUM_W-2:COORD_WIDTH-1]);
        if (pos_ovf) begin
            sat = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end else if (neg_ovf) begin
            sat = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            sat = v[COORD_WIDTH-1:0];
        end
    endfunction

    // Sum the extremes of the three terms and the translation exactly
    assign n_sum_min = SUM_W'(i_min[0]) + SUM_W'(i_min[1]) + SUM_W'(i_min[2]) + SUM_W'(i_trans);
    assign n_sum_max = SUM_W'(i_max[0]) + SUM_W'(i_max[1]) + SUM_W'(i_max[2]) + SUM_W'(i_trans);

    // Stage 4: output register
    always_ff @(posedge i_clk) begin
        if (i_ld.s4) begin
            r_min <= sat(n_sum_min);
            r_max <= sat(n_sum_max);
        end
    end

    assign o_min = r_min;
    assign o_max = r_max;

endmodule

### rtl/aabb_affine_transform.sv
// Top level of the AABB affine transform: pipeline control, register file and datapath.
//
// Maps an axis-aligned box through a 3x4 affine matrix and returns the bounding box of
// the eight mapped corners. Each output axis is found term by term: every rounded product
// is monotone in its coordinate, so the min (max) is the sum of each term's smaller
// (larger) end plus the translation, then saturated. The block takes one item per clock
// unless the output is stalled with every stage full; the four register stages are
// split partial products, the rounding add, the per-term min/max and the row sum with
// saturation, which also serves as the output register. Stages that hold no item fill
// while the output is stalled, so up to four items are held before ready drops.
// Matrix registers must be written only while no item is in flight; the block does not enforce this.
module aabb_affine_transform #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  aat_pkg::t_cfg_idx  i_cfg_idx,
    input  aat_pkg::t_cfg_data i_cfg_data,
    aat_box_in_if.sink         s_in,
    aat_box_out_if.source      m_out
);

    localparam int PROD_W = COORD_WIDTH + aat_pkg::MAT_W - aat_pkg::MAT_FRAC;

    logic signed [aat_pkg::MAT_W-1:0] w_mat   [3][3];
    logic signed [aat_pkg::MAT_W-1:0] w_trans [3];
    logic signed [COORD_WIDTH-1:0]    w_lo    [3];
    logic signed [COORD_WIDTH-1:0]    w_hi    [3];
    logic signed [PROD_W-1:0]         w_tmin  [3][3];
    logic signed [PROD_W-1:0]         w_tmax  [3][3];
    logic signed [COORD_WIDTH-1:0]    w_omin  [3];
    logic signed [COORD_WIDTH-1:0]    w_omax  [3];
    aat_pkg::t_stage_ld               w_ld;
    logic [3:0]                       r_vld;
    logic                             w_in_acc;
    logic                             w_out_acc;

    aat_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_mat   (w_mat),
        .o_trans (w_trans)
    );

    // Advance a stage when it is empty or the next stage advances
    assign w_ld.s4 = !r_vld[3] || m_out.ready;
    assign w_ld.s3 = !r_vld[2] || w_ld.s4;
    assign w_ld.s2 = !r_vld[1] || w_ld.s3;
    assign w_ld.s1 = !r_vld[0] || w_ld.s2;

    assign s_in.ready = w_ld.s1;
    assign w_in_acc   = s_in.valid && s_in.ready;
    assign w_out_acc  = m_out.valid && m_out.ready;

    // Carry valid bits along with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ld.s1) r_vld[0] <= s_in.valid;
            if (w_ld.s2) r_vld[1] <= r_vld[0];
            if (w_ld.s3) r_vld[2] <= r_vld[1];
            if (w_ld.s4) r_vld[3] <= r_vld[2];
        end
    end

    assign w_lo[0] = s_in.box_min_x;
    assign w_lo[1] = s_in.box_min_y;
    assign w_lo[2] = s_in.box_min_z;
    assign w_hi[0] = s_in.box_max_x;
    assign w_hi[1] = s_in.box_max_y;
    assign w_hi[2] = s_in.box_max_z;

    // One term per matrix entry, one summing row per output axis
    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            aat_term #(
                .COORD_WIDTH (COORD_WIDTH)
            ) u_term (
                .i_clk  (i_clk),
                .i_ld   (w_ld),
                .i_lo   (w_lo[j]),
                .i_hi   (w_hi[j]),
                .i_coef (w_mat[r][j]),
                .o_min  (w_tmin[r][j]),
                .o_max  (w_tmax[r][j])
            );
        end

        aat_row_sum #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_sum (
            .i_clk   (i_clk),
            .i_ld    (w_ld),
            .i_min   (w_tmin[r]),
            .i_max   (w_tmax[r]),
            .i_trans (w_trans[r]),
            .o_min   (w_omin[r]),
            .o_max   (w_omax[r])
        );
    end

    assign m_out.valid     = r_vld[3];
    assign m_out.out_min_x = w_omin[0];
    assign m_out.out_min_y = w_omin[1];
    assign m_out.out_min_z = w_omin[2];
    assign m_out.out_max_x = w_omax[0];
    assign m_out.out_max_y = w_omax[1];
    assign m_out.out_max_z = w_omax[2];

    // Items in flight change only by accepts on either side
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            $countones(r_vld) ==
            $past($countones(r_vld)) + int'($past(w_in_acc)) - int'($past(w_out_acc)))
        else $error("pipeline occupancy does not match accepted items");

    // A full pipeline with a stalled output takes no new item
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld) && !m_out.ready |-> !s_in.ready)
        else $error("input accepted while pipeline is full and stalled");

    // An empty output stage never holds back the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[3] |-> s_in.ready)
        else $error("input stalled with an empty output stage");

endmodule

### bench/testbench.sv
// Testbench for the box transform block: directed and random boxes checked against a predictor.
`timescale 1ns / 1ps

module testbench;
    import aat_pkg::*;

    localparam int COORD_W         = COORD_WIDTH_DEF;
    localparam int PIPE_LATENCY    = 4;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int RANDOM_PHASES   = 11;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int MAX_PRINTED     = 40;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic signed [79:0] t_wide;
    typedef logic [MAT_W-1:0]   t_entry;

    // Box: index 0 is x, 1 is y, 2 is z
    typedef struct packed {
        t_coord [2:0] hi;
        t_coord [2:0] lo;
    } t_box;

    typedef enum logic [1:0] {SPAN_FULL, SPAN_NEAR, SPAN_EDGE, SPAN_MIXED} t_span;

    localparam t_cfg_idx CFG_IDX_SPARE0 = 3'd6;
    localparam t_cfg_idx CFG_IDX_SPARE1 = 3'd7;

    localparam t_entry Q824_ONE      = 32'h0100_0000;
    localparam t_entry Q824_NEG_ONE  = 32'hFF00_0000;
    localparam t_entry Q824_HALF     = 32'h0080_0000;
    localparam t_entry Q824_NEG_HALF = 32'hFF80_0000;
    localparam t_entry WORD_ZERO     = 32'h0000_0000;
    localparam t_entry WORD_MAX      = 32'h7FFF_FFFF;
    localparam t_entry WORD_MIN      = 32'h8000_0000;
    localparam t_entry WORD_ALL_ONES = 32'hFFFF_FFFF;

    localparam t_wide ROUND_HALF = t_wide'(1) <<< (MAT_FRAC - 1);
    localparam t_wide SAT_HI     = (t_wide'(1) <<< (COORD_W - 1)) - 1;
    localparam t_wide SAT_LO     = -SAT_HI - 1;

    logic      i_clk;
    logic      i_rst_n;
    logic      cfg_we;
    t_cfg_idx  cfg_idx;
    t_cfg_data cfg_data;

    aat_box_in_if  #(.COORD_WIDTH(COORD_W)) box_in ();
    aat_box_out_if #(.COORD_WIDTH(COORD_W)) box_out ();

    t_cfg_data mat_shadow [CFG_NUM];
    t_box      expected_boxes [$];
    int        error_count;
    int        result_count;
    int        cycle_count;
    bit        steady_flow;

    aabb_affine_transform #(.COORD_WIDTH(COORD_W)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .s_in       (box_in),
        .m_out      (box_out)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report_fail(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic t_cfg_idx lin_reg_of(input int row);
        case (row)
            0:       return CFG_ROW0_COLS01;
            1:       return CFG_ROW1_COLS01;
            default: return CFG_ROW2_COLS01;
        endcase
    endfunction

    function automatic t_cfg_idx aff_reg_of(input int row);
        case (row)
            0:       return CFG_ROW0_COLS23;
            1:       return CFG_ROW1_COLS23;
            default: return CFG_ROW2_COLS23;
        endcase
    endfunction

    // Q16.16 times Q8.24, back to Q16.16 rounding half up
    function automatic t_wide round_product(input t_coord c, input t_entry m);
        t_wide cw;
        t_wide mw;
        cw = $signed(c);
        mw = $signed(m);
        return (cw * mw + ROUND_HALF) >>> MAT_FRAC;
    endfunction

    function automatic t_coord map_axis(input int row, input t_coord x, input t_coord y,
                                        input t_coord z);
        t_cfg_data lin;
        t_cfg_data aff;
        t_wide     shift;
        t_wide     acc;
        lin   = mat_shadow[lin_reg_of(row)];
        aff   = mat_shadow[aff_reg_of(row)];
        shift = $signed(aff[63:32]);
        acc   = round_product(x, lin[31:0]) + round_product(y, lin[63:32])
              + round_product(z, aff[31:0]) + shift;
        if (acc > SAT_HI)
            acc = SAT_HI;
        else if (acc < SAT_LO)
            acc = SAT_LO;
        return acc[COORD_W-1:0];
    endfunction

    // Map all eight corners and keep the per-axis extremes
    function automatic t_box predict_box(input t_box b);
        t_box   r;
        t_coord x;
        t_coord y;
        t_coord z;
        t_coord v;
        r = '0;
        for (int k = 0; k < 8; k++) begin
            x = ((k & 4) != 0) ? b.hi[0] : b.lo[0];
            y = ((k & 2) != 0) ? b.hi[1] : b.lo[1];
            z = ((k & 1) != 0) ? b.hi[2] : b.lo[2];
            for (int row = 0; row < 3; row++) begin
                v = map_axis(row, x, y, z);
                if (k == 0 || $signed(v) < $signed(r.lo[row]))
                    r.lo[row] = v;
                if (k == 0 || $signed(v) > $signed(r.hi[row]))
                    r.hi[row] = v;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random values
    // ------------------------------------------------------------------

    // Mostly short pauses, a few long ones
    function automatic int pause_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_span resolve_span(input t_span s);
        if (s == SPAN_MIXED)
            return t_span'($urandom_range(0, 2));
        return s;
    endfunction

    function automatic t_entry pick_edge_word();
        case ($urandom_range(0, 5))
            0:       return WORD_ZERO;
            1:       return WORD_MAX;
            2:       return WORD_MIN;
            3:       return WORD_ALL_ONES;
            4:       return Q824_ONE;
            default: return $urandom;
        endcase
    endfunction

    // Matrix entry, Q8.24; near span is within +-4.0
    function automatic t_entry rand_entry(input t_span s);
        case (resolve_span(s))
            SPAN_FULL: return $urandom;
            SPAN_NEAR: return 32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
            default: begin
                if ($urandom_range(0, 2) == 0)
                    return Q824_NEG_ONE;
                return pick_edge_word();
            end
        endcase
    endfunction

    // Translation, Q16.16; near span is within +-256.0
    function automatic t_entry rand_shift(input t_span s);
        case (resolve_span(s))
            SPAN_FULL: return $urandom;
            SPAN_NEAR: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
            default:   return pick_edge_word();
        endcase
    endfunction

    // Coordinate, Q16.16; near span is within +-16.0
    function automatic t_coord rand_coord(input t_span s);
        case (s)
            SPAN_FULL: return $urandom;
            SPAN_NEAR: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            default:   return pick_edge_word();
        endcase
    endfunction

    // Mostly ordered boxes, one axis in ten may come inverted
    function automatic t_box rand_box();
        t_box   b;
        t_coord a;
        t_coord c;
        t_coord tmp;
        t_span  s;
        int     r;
        for (int axis = 0; axis < 3; axis++) begin
            r = $urandom_range(0, 9);
            s = (r < 4) ? SPAN_FULL : (r < 8) ? SPAN_NEAR : SPAN_EDGE;
            a = rand_coord(s);
            c = rand_coord(s);
            if ($urandom_range(0, 9) != 0 && $signed(a) > $signed(c)) begin
                tmp = a;
                a   = c;
                c   = tmp;
            end
            b.lo[axis] = a;
            b.hi[axis] = c;
        end
        return b;
    endfunction

    function automatic t_box make_box(input t_coord lx, input t_coord ly, input t_coord lz,
                                      input t_coord hx, input t_coord hy, input t_coord hz);
        t_box b;
        b.lo = {lz, ly, lx};
        b.hi = {hz, hy, hx};
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Present one box, hold until accepted, then maybe idle
    task automatic send_box(input t_box b);
        int gap;
        box_in.valid     <= 1'b1;
        box_in.box_min_x <= b.lo[0];
        box_in.box_min_y <= b.lo[1];
        box_in.box_min_z <= b.lo[2];
        box_in.box_max_x <= b.hi[0];
        box_in.box_max_y <= b.hi[1];
        box_in.box_max_z <= b.hi[2];
        @(posedge i_clk);
        while (!box_in.ready)
            @(posedge i_clk);
        expected_boxes.push_back(predict_box(b));
        gap = 0;
        if (!steady_flow && $urandom_range(0, 99) < 30)
            gap = pause_len();
        if (gap > 0) begin
            box_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop sending and let every outstanding box come back
    task automatic pause_sender();
        box_in.valid <= 1'b0;
        while (expected_boxes.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input t_cfg_data data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx < CFG_NUM)
            mat_shadow[idx] = data;
    endtask

    task automatic write_row(input int row, input t_entry m0, input t_entry m1,
                             input t_entry m2, input t_entry shift);
        write_cfg(lin_reg_of(row), {m1, m0});
        write_cfg(aff_reg_of(row), {shift, m2});
    endtask

    // ------------------------------------------------------------------
    // Result checker and ready generator
    // ------------------------------------------------------------------
    initial begin : result_sink
        t_box  got;
        t_box  want;
        int    stall_left;
        string tag;
        box_out.ready = 1'b0;
        stall_left    = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (box_out.valid && box_out.ready) begin
                got.lo = {box_out.out_min_z, box_out.out_min_y, box_out.out_min_x};
                got.hi = {box_out.out_max_z, box_out.out_max_y, box_out.out_max_x};
                if (expected_boxes.size() == 0) begin
                    report_fail($sformatf("result %0d arrived with no box outstanding",
                                          result_count));
                end else begin
                    want = expected_boxes.pop_front();
                    for (int a = 0; a < 3; a++) begin
                        tag = (a == 0) ? "x" : (a == 1) ? "y" : "z";
                        if (got.lo[a] !== want.lo[a])
                            report_fail($sformatf("result %0d min_%s: got %h expected %h",
                                                  result_count, tag, got.lo[a], want.lo[a]));
                        if (got.hi[a] !== want.hi[a])
                            report_fail($sformatf("result %0d max_%s: got %h expected %h",
                                                  result_count, tag, got.hi[a], want.hi[a]));
                    end
                end
                result_count++;
            end
            // Drop ready for random stretches unless running steady
            if (stall_left == 0 && !steady_flow && $urandom_range(0, 99) < 20)
                stall_left = pause_len();
            if (stall_left > 0) begin
                box_out.ready <= 1'b0;
                stall_left--;
            end else begin
                box_out.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Identity after reset: extremes, inverted box, single point
    task automatic test_reset_matrix();
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX));
        send_box(make_box(32'h0005_0000, 32'h0005_0000, 32'h0005_0000,
                          32'hFFFD_0000, 32'hFFFD_0000, 32'hFFFD_0000));
        send_box(make_box(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                          32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
        send_box(make_box(32'h0001_8000, 32'hFFFD_C000, 32'h0003_0000,
                          32'h0001_8000, 32'hFFFD_C000, 32'h0003_0000));
        pause_sender();
    endtask

    // Extreme entries, rounding ties and saturating translations
    task automatic test_matrix_extremes();
        for (int row = 0; row < 3; row++)
            write_row(row, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
        send_box(make_box(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX));
        send_box(make_box(32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_FFFF, 1, 32'h0002_0000, 1));
        pause_sender();

        for (int row = 0; row < 3; row++)
            write_row(row, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
        send_box(make_box(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX));
        send_box(make_box(32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_FFFF, 1, 32'h0002_0000, 1));
        pause_sender();

        // Halves land products exactly on ties of both signs
        write_row(0, Q824_HALF, WORD_ZERO, WORD_ZERO, WORD_ZERO);
        write_row(1, WORD_ZERO, Q824_HALF, WORD_ZERO, WORD_ZERO);
        write_row(2, WORD_ZERO, WORD_ZERO, Q824_NEG_HALF, WORD_ZERO);
        send_box(make_box(-1, -3, 1, 1, 3, 1));
        send_box(make_box(-2, -1, -1, 2, 1, -1));
        send_box(make_box(32'hFFFE_7FFF, 32'h0001_8001, -5, 32'h0001_8003, 32'h0003_0005, 7));
        pause_sender();

        // Mirror every axis, push the translation to both rails
        write_row(0, Q824_NEG_ONE, WORD_ZERO, WORD_ZERO, WORD_MAX);
        write_row(1, WORD_ZERO, Q824_NEG_ONE, WORD_ZERO, WORD_MIN);
        write_row(2, WORD_ZERO, WORD_ZERO, Q824_NEG_ONE, WORD_MAX);
        send_box(make_box(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX));
        send_box(make_box(32'hFFF0_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                          32'h0010_0000, 32'h0000_0100, 32'h0000_0001));
        pause_sender();
    endtask

    // Writes beyond the register file must leave the matrix alone
    task automatic test_spare_index();
        write_cfg(CFG_IDX_SPARE0, '1);
        write_cfg(CFG_IDX_SPARE1, {2{32'h5A5A_A5A5}});
        send_box(make_box(32'hFFFF_0000, 32'hFFFE_0000, 32'hFFFD_0000,
                          32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
        pause_sender();
    endtask

    // Fresh matrix per phase, random boxes streamed through
    task automatic test_random_phases();
        t_span mspan;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            pause_sender();
            mspan = t_span'(p % 4);
            for (int row = 0; row < 3; row++)
                write_row(row, rand_entry(mspan), rand_entry(mspan), rand_entry(mspan),
                          rand_shift(mspan));
            steady_flow = (p == 5);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (p == 2 && i == ITEMS_PER_PHASE / 2)
                    pause_sender();
                send_box(rand_box());
            end
        end
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = CFG_ROW0_COLS01;
        cfg_data         = '0;
        box_in.valid     = 1'b0;
        box_in.box_min_x = '0;
        box_in.box_min_y = '0;
        box_in.box_min_z = '0;
        box_in.box_max_x = '0;
        box_in.box_max_y = '0;
        box_in.box_max_z = '0;
        steady_flow      = 1'b0;
        error_count      = 0;
        result_count     = 0;
        mat_shadow[CFG_ROW0_COLS01] = RST_ROW0_COLS01;
        mat_shadow[CFG_ROW0_COLS23] = RST_ROW0_COLS23;
        mat_shadow[CFG_ROW1_COLS01] = RST_ROW1_COLS01;
        mat_shadow[CFG_ROW1_COLS23] = RST_ROW1_COLS23;
        mat_shadow[CFG_ROW2_COLS01] = RST_ROW2_COLS01;
        mat_shadow[CFG_ROW2_COLS23] = RST_ROW2_COLS23;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_matrix();
        test_matrix_extremes();
        test_spare_index();
        test_random_phases();

        pause_sender();
        repeat (PIPE_LATENCY * 4) @(posedge i_clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
